@@ design/huf_pkg.sv @@
// Shared types and codes for the Huffman code table decoder.
package huf_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_DECODE = 2'd2;

  typedef enum logic [1:0] {
    ST_SYMBOL   = 2'd0,
    ST_BAD_CODE = 2'd1,
    ST_FULL     = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    W_IDLE,
    W_DEC,
    W_LD_WALK,
    W_LD_BUILD,
    W_LD_LEAF,
    W_LD_END
  } walk_state_t;

  typedef struct packed {
    logic       push;
    logic       done;
    logic       last;
    logic [7:0] symbol;
    status_t    status;
  } res_req_t;

  typedef struct packed {
    logic [7:0] symbol;
    status_t    status;
    logic       last;
  } res_item_t;

endpackage

@@ design/huffman_code_table_decoder_core.sv @@
// Top level of the Huffman code table decoder: sequencer, node memory, result stage.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_stall   operation, entry_symbol, code_bits,
//                                              code_length, data_byte, valid_bits
//   out       output     out_valid / out_stall decoded_symbol, status, last_of_run
//
// Decode holds the input after the item is taken while it walks the tree, for n valid bits:
// one node memory read per bit, the node of the carried-over walk is fetched as the item
// is taken, and a last step checks the final node.
// Load walks or builds one node per code bit, then writes the leaf; clear acts as the item is taken.
// Synchronous reset gives a bare root; the node memory itself is never swept.
// A stalled output holds the sequencer; an item is taken only while it is idle.
module huffman_code_table_decoder_core import huf_pkg::*; #(
  parameter int NODE_COUNT   = 511,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [7:0]  entry_symbol,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_length,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  valid_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  decoded_symbol,
  output logic [1:0]  status,
  output logic        last_of_run
);

  localparam int IW    = $clog2(NODE_COUNT);
  localparam int ENT_W = 2 * IW + 9;

  res_req_t         req;
  logic             res_ready;
  logic             mem_clear;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [ENT_W-1:0] rd_data;
  logic [ENT_W-1:0] root;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [ENT_W-1:0] wr_data;

  huf_walk #(
    .NODE_COUNT  (NODE_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .entry_symbol(entry_symbol),
    .code_bits   (code_bits),
    .code_length (code_length),
    .data_byte   (data_byte),
    .valid_bits  (valid_bits),
    .res_ready   (res_ready),
    .req         (req),
    .mem_clear   (mem_clear),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .root        (root),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  huf_node_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .clear  (mem_clear),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .root   (root)
  );

  huf_result u_result (
    .clk           (clk),
    .rst           (rst),
    .req           (req),
    .ready         (res_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .decoded_symbol(decoded_symbol),
    .status        (status),
    .last_of_run   (last_of_run)
  );

  a_err_symbol_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_SYMBOL) |-> decoded_symbol == 8'd0)
    else $error("error result carries a nonzero symbol");

  a_push_ready: assert property (@(posedge clk) disable iff (rst)
    req.push |-> res_ready)
    else $error("result pushed while result stage is full");

  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ({1'b0, wr_addr} < (IW + 1)'(NODE_COUNT)))
    else $error("node write beyond table");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en && !mem_clear)
    else $error("node write overlaps read or clear");

endmodule

@@ design/huf_node_mem.sv @@
// Node table memory with the root entry held in a register.
module huf_node_mem import huf_pkg::*; #(
  parameter int NODE_COUNT = 511
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic                              wr_en,
  input  logic [$clog2(NODE_COUNT)-1:0]     wr_addr,
  input  logic [2*$clog2(NODE_COUNT)+8:0]   wr_data,
  input  logic                              rd_en,
  input  logic [$clog2(NODE_COUNT)-1:0]     rd_addr,
  output logic [2*$clog2(NODE_COUNT)+8:0]   rd_data,
  output logic [2*$clog2(NODE_COUNT)+8:0]   root
);

  localparam int IW    = $clog2(NODE_COUNT);
  localparam int ENT_W = 2 * IW + 9;

  logic [ENT_W-1:0] mem [NODE_COUNT];
  logic [ENT_W-1:0] mem_q;
  logic             root_sel;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      root <= '0;
    end else if (wr_en && (wr_addr == '0)) begin
      root <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr != '0)) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_sel <= 1'b1;
    end else if (rd_en) begin
      root_sel <= (rd_addr == '0);
    end
  end

  assign rd_data = root_sel ? root : mem_q;

endmodule

@@ design/huf_result.sv @@
// Result holding stage and output register that marks the last result of an item.
module huf_result import huf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  res_req_t   req,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] decoded_symbol,
  output logic [1:0] status,
  output logic       last_of_run
);

  res_item_t out_r;
  res_item_t pend;
  logic      pend_v;
  logic      free;

  assign free  = !out_valid || !out_stall;
  assign ready = free && !(pend_v && pend.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
    end else if (free) begin
      if (pend_v && pend.last) begin
        out_r     <= pend;
        out_valid <= 1'b1;
        pend_v    <= 1'b0;
      end else if (req.push) begin
        out_r     <= pend;
        out_valid <= pend_v;
        pend      <= '{symbol: req.symbol, status: req.status, last: req.last};
        pend_v    <= 1'b1;
      end else if (req.done && pend_v) begin
        out_r     <= '{symbol: pend.symbol, status: pend.status, last: 1'b1};
        out_valid <= 1'b1;
        pend_v    <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign decoded_symbol = out_r.symbol;
  assign status         = out_r.status;
  assign last_of_run    = out_r.last;

endmodule

@@ design/huf_walk.sv @@
// Bit-serial sequencer for tree clear, entry load and data byte decode.
module huf_walk import huf_pkg::*; #(
  parameter int NODE_COUNT   = 511,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        operation,
  input  logic [7:0]                        entry_symbol,
  input  logic [31:0]                       code_bits,
  input  logic [5:0]                        code_length,
  input  logic [7:0]                        data_byte,
  input  logic [3:0]                        valid_bits,
  input  logic                              res_ready,
  output res_req_t                          req,
  output logic                              mem_clear,
  output logic                              rd_en,
  output logic [$clog2(NODE_COUNT)-1:0]     rd_addr,
  input  logic [2*$clog2(NODE_COUNT)+8:0]   rd_data,
  input  logic [2*$clog2(NODE_COUNT)+8:0]   root,
  output logic                              wr_en,
  output logic [$clog2(NODE_COUNT)-1:0]     wr_addr,
  output logic [2*$clog2(NODE_COUNT)+8:0]   wr_data
);

  localparam int IW    = $clog2(NODE_COUNT);
  localparam int ENT_W = 2 * IW + 9;
  localparam int NU_W  = $clog2(NODE_COUNT + 1);
  localparam int CNT_W = $clog2(MAX_CODE_LEN + 1);
  localparam int SUM_W = ((NU_W > CNT_W) ? NU_W : CNT_W) + 1;

  walk_state_t      state, state_next;
  logic [31:0]      code_sh, code_sh_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [7:0]       sym_r, sym_r_next;
  logic [7:0]       data_sh, data_sh_next;
  logic [3:0]       nb, nb_next;
  logic [IW-1:0]    cur, cur_next;
  logic             use_root, use_root_next;
  logic             chk, chk_next;
  logic [NU_W-1:0]  nodes_used, nodes_used_next;
  logic [IW-1:0]    walk_pos, walk_pos_next;

  logic             accept;
  logic [3:0]       nbs;
  logic             res_leaf;
  logic [ENT_W-1:0] base;
  logic             bit_v;
  logic [IW-1:0]    child;
  logic             missing;
  logic [IW-1:0]    fresh;
  logic             fits;
  logic [ENT_W-1:0] link_e;
  logic [ENT_W-1:0] build_e;
  logic [ENT_W-1:0] leaf_e;

  assign in_stall = (state != W_IDLE) || !res_ready;
  assign accept   = in_valid && !in_stall;
  assign nbs      = (valid_bits > 4'd8) ? 4'd8 : valid_bits;
  assign res_leaf = rd_data[ENT_W-1];

  always_comb begin
    if (state == W_DEC && chk) begin
      base = res_leaf ? root : rd_data;
    end else begin
      base = use_root ? root : rd_data;
    end
  end

  assign bit_v   = (state == W_DEC) ? data_sh[0] : code_sh[0];
  assign child   = bit_v ? base[2*IW-1:IW] : base[IW-1:0];
  assign missing = (child == '0) || ({1'b0, child} >= (IW + 1)'(NODE_COUNT));
  assign fresh   = nodes_used[IW-1:0];
  assign fits    = (SUM_W'(nodes_used) + SUM_W'(cnt)) <= SUM_W'(NODE_COUNT);
  assign link_e  = bit_v ? {base[ENT_W-1:2*IW], fresh, base[IW-1:0]}
                         : {base[ENT_W-1:IW], fresh};
  assign build_e = bit_v ? {{(ENT_W-2*IW){1'b0}}, fresh, {IW{1'b0}}}
                         : {{(ENT_W-IW){1'b0}}, fresh};
  assign leaf_e  = {1'b1, sym_r, {(2*IW){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= W_IDLE;
      chk        <= 1'b0;
      use_root   <= 1'b1;
      nodes_used <= NU_W'(1);
      walk_pos   <= '0;
    end else begin
      state      <= state_next;
      chk        <= chk_next;
      use_root   <= use_root_next;
      nodes_used <= nodes_used_next;
      walk_pos   <= walk_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    code_sh <= code_sh_next;
    cnt     <= cnt_next;
    sym_r   <= sym_r_next;
    data_sh <= data_sh_next;
    nb      <= nb_next;
    cur     <= cur_next;
  end

  always_comb begin
    state_next      = state;
    code_sh_next    = code_sh;
    cnt_next        = cnt;
    sym_r_next      = sym_r;
    data_sh_next    = data_sh;
    nb_next         = nb;
    cur_next        = cur;
    use_root_next   = use_root;
    chk_next        = chk;
    nodes_used_next = nodes_used;
    walk_pos_next   = walk_pos;
    req             = '0;
    mem_clear       = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = child;
    wr_en           = 1'b0;
    wr_addr         = cur;
    wr_data         = leaf_e;

    case (state)
      W_IDLE: begin
        if (accept) begin
          case (operation)
            OP_CLEAR: begin
              mem_clear       = 1'b1;
              nodes_used_next = NU_W'(1);
              walk_pos_next   = '0;
            end
            OP_LOAD: begin
              if ((code_length == 6'd0) || (code_length > MAX_CODE_LEN)) begin
                req.push   = 1'b1;
                req.last   = 1'b1;
                req.status = ST_BAD_CODE;
              end else begin
                sym_r_next    = entry_symbol;
                code_sh_next  = code_bits;
                cnt_next      = CNT_W'(code_length);
                cur_next      = '0;
                use_root_next = 1'b1;
                state_next    = W_LD_WALK;
              end
            end
            OP_DECODE: begin
              if (nbs != 4'd0) begin
                rd_en         = 1'b1;
                rd_addr       = walk_pos;
                data_sh_next  = data_byte;
                nb_next       = nbs;
                use_root_next = 1'b0;
                chk_next      = 1'b0;
                state_next    = W_DEC;
              end
            end
            default: begin
            end
          endcase
        end
      end

      W_DEC: begin
        if (res_ready) begin
          if (chk) begin
            if (res_leaf) begin
              req.push      = 1'b1;
              req.last      = (nb == 4'd0);
              req.symbol    = rd_data[ENT_W-2:2*IW];
              req.status    = ST_SYMBOL;
              walk_pos_next = '0;
            end else begin
              walk_pos_next = cur;
            end
            if (nb == 4'd0) begin
              req.done   = !res_leaf;
              chk_next   = 1'b0;
              state_next = W_IDLE;
            end else if (missing) begin
              chk_next      = 1'b0;
              use_root_next = res_leaf;
            end else begin
              rd_en        = 1'b1;
              cur_next     = child;
              data_sh_next = data_sh >> 1;
              nb_next      = nb - 4'd1;
            end
          end else begin
            data_sh_next = data_sh >> 1;
            nb_next      = nb - 4'd1;
            if (missing) begin
              req.push      = 1'b1;
              req.last      = (nb == 4'd1);
              req.status    = ST_MISSING;
              walk_pos_next = '0;
              use_root_next = 1'b1;
              if (nb == 4'd1) begin
                state_next = W_IDLE;
              end
            end else begin
              rd_en    = 1'b1;
              cur_next = child;
              chk_next = 1'b1;
            end
          end
        end
      end

      W_LD_WALK: begin
        if (res_ready) begin
          if (base[ENT_W-1]) begin
            req.push   = 1'b1;
            req.last   = 1'b1;
            req.status = ST_BAD_CODE;
            state_next = W_IDLE;
          end else if (child == '0) begin
            if (!fits) begin
              req.push   = 1'b1;
              req.last   = 1'b1;
              req.status = ST_FULL;
              state_next = W_IDLE;
            end else begin
              wr_en           = 1'b1;
              wr_data         = link_e;
              cur_next        = fresh;
              nodes_used_next = nodes_used + NU_W'(1);
              code_sh_next    = code_sh >> 1;
              cnt_next        = cnt - CNT_W'(1);
              state_next      = (cnt == CNT_W'(1)) ? W_LD_LEAF : W_LD_BUILD;
            end
          end else begin
            rd_en         = 1'b1;
            cur_next      = child;
            use_root_next = 1'b0;
            code_sh_next  = code_sh >> 1;
            cnt_next      = cnt - CNT_W'(1);
            state_next    = (cnt == CNT_W'(1)) ? W_LD_END : W_LD_WALK;
          end
        end
      end

      W_LD_BUILD: begin
        if (res_ready) begin
          wr_en           = 1'b1;
          wr_data         = build_e;
          cur_next        = fresh;
          nodes_used_next = nodes_used + NU_W'(1);
          code_sh_next    = code_sh >> 1;
          cnt_next        = cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state_next = W_LD_LEAF;
          end
        end
      end

      W_LD_LEAF: begin
        if (res_ready) begin
          wr_en      = 1'b1;
          req.push   = 1'b1;
          req.last   = 1'b1;
          req.symbol = sym_r;
          req.status = ST_SYMBOL;
          state_next = W_IDLE;
        end
      end

      W_LD_END: begin
        if (res_ready) begin
          req.push   = 1'b1;
          req.last   = 1'b1;
          state_next = W_IDLE;
          if (!base[ENT_W-1] && ((base[2*IW-1:IW] != '0) || (base[IW-1:0] != '0))) begin
            req.status = ST_BAD_CODE;
          end else begin
            wr_en      = 1'b1;
            req.symbol = sym_r;
            req.status = ST_SYMBOL;
          end
        end
      end

      default: begin
        state_next = W_IDLE;
      end
    endcase
  end

endmodule
